[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the ARP cache RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ACR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ACR_ASSERT_NEVER(lbl, cond, msg) \
  `ACR_ASSERT(lbl, !(cond), msg)

`endif

[hdl/acr_pkg.sv]
// ----------------------------------------------------------------------------
// acr_pkg
// Types and constants shared by the ARP cache and responder modules.
// ----------------------------------------------------------------------------
package acr_pkg;

  // Item kinds
  localparam logic [1:0] MODE_ARP     = 2'd0;
  localparam logic [1:0] MODE_IP      = 2'd1;
  localparam logic [1:0] MODE_RESOLVE = 2'd2;

  // ARP header checks
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
  localparam logic [7:0]  IP_ADDR_LEN = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes
  localparam int   CFG_IDX_W  = 1;
  localparam logic REG_MY_IP  = 1'b0;
  localparam logic REG_MY_MAC = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic mac_rd;
    logic write;
    logic result;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
    logic hit;
    logic ins_go;
  } status_t;

endpackage

[hdl/acr_ctrl.sv]
// ----------------------------------------------------------------------------
// acr_ctrl
// Sequencer for one request: table scan, decision, result.
// ----------------------------------------------------------------------------
module acr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  acr_pkg::status_t status_i,
  output logic             busy_o,
  output acr_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: state_d = S_RESULT;
      S_RESULT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.mac_rd = (state_q == S_DECIDE) && status_i.hit;
    cmd_o.write  = (state_q == S_DECIDE) && status_i.ins_go;
    cmd_o.result = (state_q == S_RESULT);
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hdl/acr_datapath.sv]
// ----------------------------------------------------------------------------
// acr_datapath
// Request registers, IP/MAC table memories, scan compare and result registers.
// ----------------------------------------------------------------------------
module acr_datapath #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acr_pkg::cmd_t    cmd_i,
  output acr_pkg::status_t status_o,
  input  logic             my_ip_we_i,
  input  logic [31:0]      my_ip_i,
  input  logic [1:0]       mode_i,
  input  logic [47:0]      src_mac_i,
  input  logic [31:0]      src_ip_i,
  input  logic [15:0]      hw_type_i,
  input  logic [15:0]      proto_type_i,
  input  logic [7:0]       hw_len_i,
  input  logic [7:0]       proto_len_i,
  input  logic [15:0]      arp_opcode_i,
  input  logic [31:0]      target_ip_in_i,
  input  logic [47:0]      target_mac_in_i,
  input  logic [31:0]      dest_ip_i,
  output logic             done_o,
  output logic             send_reply_o,
  output logic             found_o,
  output logic [47:0]      eth_dest_mac_o,
  output logic [47:0]      reply_target_mac_o,
  output logic [31:0]      reply_target_ip_o,
  output logic             inserted_o,
  output logic             table_full_o
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

  // Own address
  logic [31:0] my_ip_q;

  // Request registers
  logic [47:0] src_mac_q;
  logic [31:0] src_ip_q;
  logic [47:0] tmac_in_q;
  logic [31:0] key_q;
  logic        active_q;
  logic        send_q;
  logic        ins_req_q;

  // Table storage
  logic [31:0]            ip_mem  [TABLE_DEPTH];
  logic [47:0]            mac_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;

  // Scan state
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      ip_rd_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;
  logic             ins_done_q;
  logic [47:0]      mac_rd_q;
  logic             scan_more;
  logic             slot_match;
  logic             slot_free;

  // Decoded request
  logic        arp_ok;
  logic        key_load_active;
  logic        key_load_ins;
  logic        key_load_send;
  logic [31:0] key_load;

  // Result
  logic        res_found;
  logic [47:0] res_dmac;
  logic        strobe_q;

  // Check the ARP header and pick the lookup address
  always_comb begin
    arp_ok = (hw_type_i == acr_pkg::HW_ETHERNET) && (proto_type_i == acr_pkg::PROTO_IPV4) &&
             (hw_len_i == acr_pkg::HW_ADDR_LEN) && (proto_len_i == acr_pkg::IP_ADDR_LEN) &&
             (target_ip_in_i == my_ip_q) &&
             ((arp_opcode_i == acr_pkg::OP_REQUEST) || (arp_opcode_i == acr_pkg::OP_REPLY));
    key_load_active = 1'b0;
    key_load_ins    = 1'b0;
    key_load_send   = 1'b0;
    key_load        = src_ip_i;
    case (mode_i)
      acr_pkg::MODE_ARP: begin
        key_load_active = arp_ok;
        key_load_ins    = arp_ok && (src_ip_i != '0);
        key_load_send   = arp_ok && (arp_opcode_i == acr_pkg::OP_REQUEST);
      end
      acr_pkg::MODE_IP: begin
        key_load_active = 1'b1;
        key_load_ins    = (src_ip_i != '0);
      end
      acr_pkg::MODE_RESOLVE: begin
        key_load_active = 1'b1;
        key_load        = dest_ip_i;
      end
      default: ;
    endcase
  end

  // Hold own IP address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q <= '0;
    end else if (my_ip_we_i) begin
      my_ip_q <= my_ip_i;
    end
  end

  // Capture request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_mac_q <= src_mac_i;
      src_ip_q  <= src_ip_i;
      tmac_in_q <= target_mac_in_i;
      key_q     <= key_load;
    end
  end

  // Scan compare on the entry read in the previous cycle
  assign scan_more  = (cnt_q != CNT_END);
  assign rd_idx     = cnt_q[IDX_W-1:0];
  assign slot_match = cmp_vld_q && valid_q[cmp_idx_q] && (ip_rd_q == key_q);
  assign slot_free  = cmp_vld_q && !valid_q[cmp_idx_q];

  // Control flags, scan counter and search results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      send_q     <= 1'b0;
      ins_req_q  <= 1'b0;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      ins_done_q <= 1'b0;
      valid_q    <= '0;
    end else if (cmd_i.load) begin
      active_q   <= key_load_active;
      send_q     <= key_load_send;
      ins_req_q  <= key_load_ins;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      ins_done_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (scan_more) cnt_q <= cnt_q + 1'b1;
      cmp_vld_q <= scan_more;
      cmp_idx_q <= rd_idx;
      // keep the lowest match and the lowest free slot
      if (slot_match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
      end
      if (slot_free && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
    end else if (cmd_i.write) begin
      valid_q[free_idx_q] <= 1'b1;
      ins_done_q          <= 1'b1;
    end
  end

  // IP table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      ip_mem[free_idx_q] <= key_q;
    end
    if (cmd_i.scan && scan_more) begin
      ip_rd_q <= ip_mem[rd_idx];
    end
  end

  // MAC table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mac_mem[free_idx_q] <= src_mac_q;
    end
    if (cmd_i.mac_rd) begin
      mac_rd_q <= mac_mem[hit_idx_q];
    end
  end

  // Report scan progress and the insert decision
  always_comb begin
    status_o           = '0;
    status_o.scan_last = !scan_more;
    status_o.hit       = hit_q;
    status_o.ins_go    = ins_req_q && !hit_q && free_q;
  end

  // Form the result; a new entry carries the source MAC just written
  assign res_found = hit_q || ins_done_q;
  assign res_dmac  = hit_q ? mac_rd_q : (ins_done_q ? src_mac_q : acr_pkg::BCAST_MAC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      send_reply_o       <= active_q && send_q;
      found_o            <= active_q && res_found;
      eth_dest_mac_o     <= active_q ? res_dmac : '0;
      reply_target_mac_o <= (active_q && send_q) ? (res_found ? res_dmac : tmac_in_q) : '0;
      reply_target_ip_o  <= (active_q && send_q) ? src_ip_q : '0;
      inserted_o         <= active_q && ins_done_q;
      table_full_o       <= active_q && ins_req_q && !hit_q && !ins_done_q;
    end
  end

  // One-cycle result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.result;
    end
  end

  assign done_o = strobe_q;

endmodule

[hdl/arp_cache_responder.sv]
// A request taken at start goes through the table scan (registered read, then a compare on
// the entry read), a decision state and a result state; the result strobe is registered
// from the result state. A new request is taken only in idle, after the previous one has
// left the result state.
// Reset: clears the controller, all table entry valid bits and my_ip.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// arp_cache_responder
// ARP cache with request responder: checks ARP packets, learns senders,
// resolves IPv4 addresses to MAC addresses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_cache_responder #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [acr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [47:0]                    cfg_data_i,
  input  logic [1:0]                     mode_i,
  input  logic [47:0]                    src_mac_i,
  input  logic [31:0]                    src_ip_i,
  input  logic [15:0]                    hw_type_i,
  input  logic [15:0]                    proto_type_i,
  input  logic [7:0]                     hw_len_i,
  input  logic [7:0]                     proto_len_i,
  input  logic [15:0]                    arp_opcode_i,
  input  logic [31:0]                    target_ip_in_i,
  input  logic [47:0]                    target_mac_in_i,
  input  logic [31:0]                    dest_ip_i,
  output logic                           done_o,
  output logic                           send_reply_o,
  output logic                           found_o,
  output logic [47:0]                    eth_dest_mac_o,
  output logic [47:0]                    reply_target_mac_o,
  output logic [31:0]                    reply_target_ip_o,
  output logic                           inserted_o,
  output logic                           table_full_o
);

  acr_pkg::cmd_t    cmd;
  acr_pkg::status_t status;
  logic             my_ip_we;

  // Accept configuration whenever no request is in flight
  assign cfg_ready_o = !busy;

  // Decode register writes; the sender MAC feeds no result and is dropped
  always_comb begin
    my_ip_we = 1'b0;
    unique case (cfg_index_i)
      acr_pkg::REG_MY_IP:  my_ip_we = cfg_valid_i && cfg_ready_o;
      acr_pkg::REG_MY_MAC: my_ip_we = 1'b0;
      default:             my_ip_we = 1'b0;
    endcase
  end

  acr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  acr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .my_ip_we_i         (my_ip_we),
    .my_ip_i            (cfg_data_i[31:0]),
    .mode_i             (mode_i),
    .src_mac_i          (src_mac_i),
    .src_ip_i           (src_ip_i),
    .hw_type_i          (hw_type_i),
    .proto_type_i       (proto_type_i),
    .hw_len_i           (hw_len_i),
    .proto_len_i        (proto_len_i),
    .arp_opcode_i       (arp_opcode_i),
    .target_ip_in_i     (target_ip_in_i),
    .target_mac_in_i    (target_mac_in_i),
    .dest_ip_i          (dest_ip_i),
    .done_o             (done_o),
    .send_reply_o       (send_reply_o),
    .found_o            (found_o),
    .eth_dest_mac_o     (eth_dest_mac_o),
    .reply_target_mac_o (reply_target_mac_o),
    .reply_target_ip_o  (reply_target_ip_o),
    .inserted_o         (inserted_o),
    .table_full_o       (table_full_o)
  );

  // Checks
  `ACR_ASSERT(a_start_busy, start && !busy |=> busy, "accepted request did not raise busy")
  `ACR_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  `ACR_ASSERT_NEVER(a_ins_full, done_o && inserted_o && table_full_o, "insert and full together")
  `ACR_ASSERT(a_no_reply_ip, done_o && !send_reply_o |-> reply_target_ip_o == '0, "reply IP without reply")
  `ACR_ASSERT_NEVER(a_hit_write, cmd.mac_rd && cmd.write, "table hit and insert in one request")

endmodule

[test/arp_cache_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_cache_checker
// Watches the request, register and result channels of the ARP cache,
// keeps its own IP-to-MAC table and registers, works out the outcome of
// every accepted request and compares each result strobe with the oldest
// outcome still due.
// ----------------------------------------------------------------------------
module arp_cache_checker
  import acr_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [47:0]          cfg_data_i,
  input  logic [1:0]           mode_i,
  input  logic [47:0]          src_mac_i,
  input  logic [31:0]          src_ip_i,
  input  logic [15:0]          hw_type_i,
  input  logic [15:0]          proto_type_i,
  input  logic [7:0]           hw_len_i,
  input  logic [7:0]           proto_len_i,
  input  logic [15:0]          arp_opcode_i,
  input  logic [31:0]          target_ip_in_i,
  input  logic [47:0]          target_mac_in_i,
  input  logic [31:0]          dest_ip_i,
  input  logic                 done_i,
  input  logic                 send_reply_i,
  input  logic                 found_i,
  input  logic [47:0]          eth_dest_mac_i,
  input  logic [47:0]          reply_target_mac_i,
  input  logic [31:0]          reply_target_ip_i,
  input  logic                 inserted_i,
  input  logic                 table_full_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   replies_o,
  output int                   inserts_o,
  output int                   full_o,
  output int                   hits_o
);

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [31:0] dest_ip;
  } arp_req_t;

  typedef struct packed {
    logic        send_reply;
    logic        found;
    logic [47:0] eth_dest_mac;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic        inserted;
    logic        table_full;
  } arp_outcome_t;

  // Own copy of the registers and the table
  logic [31:0] my_ip_q;
  logic [47:0] my_mac_q;  // sender data for the frame builder, no effect on results
  logic [31:0] ip_tab  [TABLE_DEPTH];
  logic [47:0] mac_tab [TABLE_DEPTH];

  arp_outcome_t outcome_q[$];

  // Return the lowest slot holding ip, or TABLE_DEPTH when there is none
  function automatic int find_slot(input logic [31:0] ip);
    if (ip == '0) return TABLE_DEPTH;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ip_tab[i] == ip) return i;
    end
    return TABLE_DEPTH;
  endfunction

  // Learn ip/mac into the lowest free slot; return {inserted, table_full}
  function automatic logic [1:0] learn_entry(input logic [31:0] ip, input logic [47:0] mac);
    if (ip == '0 || find_slot(ip) < TABLE_DEPTH) return 2'b00;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ip_tab[i] == '0) begin
        ip_tab[i]  = ip;
        mac_tab[i] = mac;
        return 2'b10;
      end
    end
    return 2'b01;
  endfunction

  // Work out the result of one request and update the table
  function automatic arp_outcome_t arp_outcome(input arp_req_t r);
    arp_outcome_t res;
    logic         do_lookup;
    logic         do_reply;
    logic [31:0]  look_ip;
    int           slot;
    res       = '0;
    do_lookup = 1'b0;
    do_reply  = 1'b0;
    look_ip   = '0;
    case (r.mode)
      MODE_ARP: begin
        if (r.hw_type == HW_ETHERNET && r.proto_type == PROTO_IPV4 &&
            r.hw_len == HW_ADDR_LEN && r.proto_len == IP_ADDR_LEN &&
            r.target_ip == my_ip_q &&
            (r.opcode == OP_REQUEST || r.opcode == OP_REPLY)) begin
          {res.inserted, res.table_full} = learn_entry(r.src_ip, r.src_mac);
          do_lookup = 1'b1;
          look_ip   = r.src_ip;
          do_reply  = (r.opcode == OP_REQUEST);
        end
      end
      MODE_IP: begin
        {res.inserted, res.table_full} = learn_entry(r.src_ip, r.src_mac);
        do_lookup = 1'b1;
        look_ip   = r.src_ip;
      end
      MODE_RESOLVE: begin
        do_lookup = 1'b1;
        look_ip   = r.dest_ip;
      end
      default: ;  // unused mode: all fields zero
    endcase
    if (do_lookup) begin
      slot             = find_slot(look_ip);
      res.found        = (slot < TABLE_DEPTH);
      res.eth_dest_mac = res.found ? mac_tab[slot] : BCAST_MAC;
    end
    if (do_reply) begin
      res.send_reply       = 1'b1;
      res.reply_target_mac = res.found ? res.eth_dest_mac : r.target_mac;
      res.reply_target_ip  = r.src_ip;
    end
    return res;
  endfunction

  // Count one mismatch and print it while no more than 40 have been counted
  task automatic report_mismatch(input string field, input logic [47:0] want,
                                 input logic [47:0] got);
    errors_o++;
    if (errors_o <= 40) begin
      $display("%0t: result %0d, %s: expected %h, got %h", $realtime, checked_o,
               field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    arp_req_t     req;
    arp_outcome_t want;
    if (!rst_ni) begin
      my_ip_q  = '0;
      my_mac_q = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        ip_tab[i]  = '0;
        mac_tab[i] = '0;
      end
      outcome_q.delete();
      errors_o  = 0;
      checked_o = 0;
      replies_o = 0;
      inserts_o = 0;
      full_o    = 0;
      hits_o    = 0;
    end else begin
      // Apply register writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MY_IP) my_ip_q = cfg_data_i[31:0];
        else if (cfg_index_i == REG_MY_MAC) my_mac_q = cfg_data_i;
      end

      // Compare a result strobe with the oldest outcome due
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, '0);
        end else begin
          want = outcome_q.pop_front();
          if (send_reply_i !== want.send_reply)
            report_mismatch("send_reply", 48'(want.send_reply), 48'(send_reply_i));
          if (found_i !== want.found)
            report_mismatch("found", 48'(want.found), 48'(found_i));
          if (eth_dest_mac_i !== want.eth_dest_mac)
            report_mismatch("eth_dest_mac", want.eth_dest_mac, eth_dest_mac_i);
          if (reply_target_mac_i !== want.reply_target_mac)
            report_mismatch("reply_target_mac", want.reply_target_mac, reply_target_mac_i);
          if (reply_target_ip_i !== want.reply_target_ip)
            report_mismatch("reply_target_ip", 48'(want.reply_target_ip),
                            48'(reply_target_ip_i));
          if (inserted_i !== want.inserted)
            report_mismatch("inserted", 48'(want.inserted), 48'(inserted_i));
          if (table_full_i !== want.table_full)
            report_mismatch("table_full", 48'(want.table_full), 48'(table_full_i));
        end
        checked_o++;
      end

      // Predict each accepted request
      if (start_i && !busy_i) begin
        req = '{mode: mode_i, src_mac: src_mac_i, src_ip: src_ip_i, hw_type: hw_type_i,
                proto_type: proto_type_i, hw_len: hw_len_i, proto_len: proto_len_i,
                opcode: arp_opcode_i, target_ip: target_ip_in_i,
                target_mac: target_mac_in_i, dest_ip: dest_ip_i};
        want = arp_outcome(req);
        replies_o += int'(want.send_reply);
        inserts_o += int'(want.inserted);
        full_o    += int'(want.table_full);
        hits_o    += int'(want.found);
        outcome_q.push_back(want);
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

[test/tb_arp_cache_responder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_cache_responder
// Drives ARP packets, IPv4 packets and resolve queries into the ARP cache:
// a directed pass over header checks, address zero, table fill and overflow,
// then three random phases with different own addresses and sender gaps.
// Results are checked by the attached checker.
// ----------------------------------------------------------------------------
module tb_arp_cache_responder;
  import acr_pkg::*;

  localparam int          DEPTH           = 8;
  localparam int          LATENCY         = DEPTH + 3;
  localparam int          ITEMS_PER_PHASE = 183;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [31:0] dest_ip;
  } req_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [47:0]          cfg_data_i;
  logic [1:0]           mode_i;
  logic [47:0]          src_mac_i;
  logic [31:0]          src_ip_i;
  logic [15:0]          hw_type_i;
  logic [15:0]          proto_type_i;
  logic [7:0]           hw_len_i;
  logic [7:0]           proto_len_i;
  logic [15:0]          arp_opcode_i;
  logic [31:0]          target_ip_in_i;
  logic [47:0]          target_mac_in_i;
  logic [31:0]          dest_ip_i;
  logic                 done_o;
  logic                 send_reply_o;
  logic                 found_o;
  logic [47:0]          eth_dest_mac_o;
  logic [47:0]          reply_target_mac_o;
  logic [31:0]          reply_target_ip_o;
  logic                 inserted_o;
  logic                 table_full_o;

  int err_count;
  int pending;
  int n_checked;
  int n_replies;
  int n_inserts;
  int n_full;
  int n_hits;
  int idle_pct;
  int idle_cycles;

  logic [31:0] my_ip_now;
  logic [31:0] stored_ip [8];
  logic [31:0] fresh_ip  [6];

  arp_cache_responder #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .mode_i, .src_mac_i, .src_ip_i, .hw_type_i, .proto_type_i,
    .hw_len_i, .proto_len_i, .arp_opcode_i, .target_ip_in_i, .target_mac_in_i,
    .dest_ip_i, .done_o, .send_reply_o, .found_o, .eth_dest_mac_o,
    .reply_target_mac_o, .reply_target_ip_o, .inserted_o, .table_full_o
  );

  arp_cache_checker #(.TABLE_DEPTH(DEPTH)) u_arp_check (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i, .mode_i, .src_mac_i,
    .src_ip_i, .hw_type_i, .proto_type_i, .hw_len_i, .proto_len_i, .arp_opcode_i,
    .target_ip_in_i, .target_mac_in_i, .dest_ip_i, .done_i(done_o),
    .send_reply_i(send_reply_o), .found_i(found_o), .eth_dest_mac_i(eth_dest_mac_o),
    .reply_target_mac_i(reply_target_mac_o), .reply_target_ip_i(reply_target_ip_o),
    .inserted_i(inserted_o), .table_full_i(table_full_o),
    .errors_o(err_count), .pending_o(pending), .checked_o(n_checked),
    .replies_o(n_replies), .inserts_o(n_inserts), .full_o(n_full), .hits_o(n_hits)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // End the run when no channel has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no channel activity for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Fully random request, every bit of every field free
  function automatic req_t rand_req();
    req_t r;
    r.mode       = 2'($urandom);
    r.src_mac    = rand48();
    r.src_ip     = $urandom;
    r.hw_type    = 16'($urandom);
    r.proto_type = 16'($urandom);
    r.hw_len     = 8'($urandom);
    r.proto_len  = 8'($urandom);
    r.opcode     = 16'($urandom);
    r.target_ip  = $urandom;
    r.target_mac = rand48();
    r.dest_ip    = $urandom;
    return r;
  endfunction

  // Well-formed ARP packet aimed at our own address
  function automatic req_t good_arp(input logic [15:0] op, input logic [31:0] sip);
    req_t r;
    r            = rand_req();
    r.mode       = MODE_ARP;
    r.src_ip     = sip;
    r.hw_type    = HW_ETHERNET;
    r.proto_type = PROTO_IPV4;
    r.hw_len     = HW_ADDR_LEN;
    r.proto_len  = IP_ADDR_LEN;
    r.opcode     = op;
    r.target_ip  = my_ip_now;
    return r;
  endfunction

  // Mix of table entries, unknown addresses and address zero
  function automatic logic [31:0] pick_ip();
    int k;
    k = $urandom_range(99);
    if (k < 40) return stored_ip[$urandom_range(7)];
    if (k < 70) return fresh_ip[$urandom_range(5)];
    if (k < 75) return '0;
    return $urandom;
  endfunction

  // Present one request, with an optional sender gap, and wait until it is taken
  task automatic send_req(input req_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    mode_i          <= r.mode;
    src_mac_i       <= r.src_mac;
    src_ip_i        <= r.src_ip;
    hw_type_i       <= r.hw_type;
    proto_type_i    <= r.proto_type;
    hw_len_i        <= r.hw_len;
    proto_len_i     <= r.proto_len;
    arp_opcode_i    <= r.opcode;
    target_ip_in_i  <= r.target_ip;
    target_mac_in_i <= r.target_mac;
    dest_ip_i       <= r.dest_ip;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off requests until every result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_MY_IP) my_ip_now = data[31:0];
  endtask

  initial begin
    req_t r;
    int   k;
    rst_ni          = 1'b0;
    start           = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    mode_i          = '0;
    src_mac_i       = '0;
    src_ip_i        = '0;
    hw_type_i       = '0;
    proto_type_i    = '0;
    hw_len_i        = '0;
    proto_len_i     = '0;
    arp_opcode_i    = '0;
    target_ip_in_i  = '0;
    target_mac_in_i = '0;
    dest_ip_i       = '0;
    idle_cycles     = 0;
    idle_pct        = 15;
    my_ip_now       = '0;
    for (int i = 0; i < 7; i++) stored_ip[i] = 32'h0A00_0010 + 32'(i * 3);
    stored_ip[7] = 32'hFFFF_FFFF;
    for (int i = 0; i < 6; i++) fresh_ip[i] = 32'hAC10_0100 + 32'(i * 7);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: header checks, address zero, fill and overflow of the table
    write_reg(REG_MY_IP, 48'hC0A8_0001);
    write_reg(REG_MY_MAC, 48'h0200_5E10_2030);
    send_req(good_arp(OP_REQUEST, stored_ip[0]));
    r = good_arp(OP_REPLY, stored_ip[1]);
    r.src_mac = '1;
    send_req(r);
    send_req(good_arp(OP_REQUEST, stored_ip[0]));  // known sender, new MAC not taken
    r = good_arp(OP_REQUEST, fresh_ip[0]); r.hw_type = 16'h0100;    send_req(r);
    r = good_arp(OP_REQUEST, fresh_ip[0]); r.proto_type = 16'h0008; send_req(r);
    r = good_arp(OP_REQUEST, fresh_ip[0]); r.hw_len = 8'h00;        send_req(r);
    r = good_arp(OP_REQUEST, fresh_ip[0]); r.proto_len = 8'hFF;     send_req(r);
    r = good_arp(OP_REQUEST, fresh_ip[0]); r.target_ip = ~my_ip_now; send_req(r);
    send_req(good_arp(16'h0000, fresh_ip[0]));
    send_req(good_arp(16'h0003, fresh_ip[0]));
    send_req(good_arp(16'hFFFF, fresh_ip[0]));
    send_req(good_arp(OP_REQUEST, '0));            // sender address zero
    r = rand_req(); r.mode = MODE_IP; r.src_ip = '0; send_req(r);
    r = rand_req(); r.mode = MODE_IP; r.src_ip = stored_ip[2]; r.src_mac = '0; send_req(r);
    r = rand_req(); r.mode = MODE_IP; r.src_ip = stored_ip[0]; send_req(r);
    r = rand_req(); r.mode = MODE_RESOLVE; r.dest_ip = stored_ip[1]; send_req(r);
    r = rand_req(); r.mode = MODE_RESOLVE; r.dest_ip = fresh_ip[1];  send_req(r);
    r = rand_req(); r.mode = MODE_RESOLVE; r.dest_ip = '0;           send_req(r);
    r = rand_req(); r.mode = MODE_UNUSED; send_req(r);
    for (int i = 3; i < 8; i++) begin
      r = rand_req(); r.mode = MODE_IP; r.src_ip = stored_ip[i]; send_req(r);
    end
    r = rand_req(); r.mode = MODE_IP; r.src_ip = fresh_ip[2]; send_req(r);  // table full
    send_req(good_arp(OP_REQUEST, fresh_ip[3]));   // full, reply passes target MAC on
    r = rand_req(); r.mode = MODE_RESOLVE; r.dest_ip = stored_ip[7]; send_req(r);

    // Random phases, each with its own registers and sender gaps
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_MY_IP, {16'h0, 32'($urandom)});
          write_reg(REG_MY_MAC, '0);
          idle_pct = 15;
        end
        1: begin
          write_reg(REG_MY_IP, 48'hFFFF_FFFF);
          write_reg(REG_MY_MAC, '1);
          idle_pct = 45;
        end
        default: begin
          write_reg(REG_MY_IP, '0);
          write_reg(REG_MY_MAC, rand48());
          idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        k = $urandom_range(99);
        if (k < 45) begin
          r = good_arp(($urandom_range(99) < 60) ? OP_REQUEST : OP_REPLY, pick_ip());
        end else if (k < 55) begin
          // Break one header field of an otherwise good packet
          r = good_arp(OP_REQUEST, pick_ip());
          case ($urandom_range(5))
            0: r.hw_type    ^= 16'(1 << $urandom_range(15));
            1: r.proto_type ^= 16'(1 << $urandom_range(15));
            2: r.hw_len     ^= 8'(1 << $urandom_range(7));
            3: r.proto_len  ^= 8'(1 << $urandom_range(7));
            4: r.target_ip  ^= 32'(1 << $urandom_range(31));
            default: r.opcode = ($urandom_range(3) == 0) ? 16'h0000
                                                         : 16'($urandom_range(3, 16'hFFFF));
          endcase
        end else if (k < 70) begin
          r = rand_req(); r.mode = MODE_IP; r.src_ip = pick_ip();
        end else if (k < 85) begin
          r = rand_req(); r.mode = MODE_RESOLVE; r.dest_ip = pick_ip();
        end else begin
          r = rand_req();
        end
        send_req(r);
      end
    end

    // Wait for the last results, then watch for stray strobes
    drain();
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("Checked %0d results over a directed pass and three register settings.",
             n_checked);
    $display("Replies %0d, inserts %0d, table-full %0d, lookups found %0d, mismatches %0d.",
             n_replies, n_inserts, n_full, n_hits, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/acr_pkg.sv
hdl/acr_ctrl.sv
hdl/acr_datapath.sv
hdl/arp_cache_responder.sv
test/arp_cache_checker.sv
test/tb_arp_cache_responder.sv
